@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// Build with NO_ASSERTIONS defined to strip every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge outside of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check that a condition leads to another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (conseq)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, cond, conseq)

`endif

`endif

@@ hdl/pdd_pkg.sv @@
`timescale 1ns / 1ps

package pdd_pkg;

    localparam int TIME_W   = 64;
    localparam int HANDLE_W = 16;
    localparam int FILL_W   = 7;
    localparam int LIMIT_W  = 7;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;

    localparam logic [TIME_W-1:0] NO_TIME  = {1'b1, {(TIME_W-1){1'b0}}};
    localparam logic [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND     = 3'd0,
        REQ_TAKE       = 3'd1,
        REQ_RETURN     = 3'd2,
        REQ_DROP       = 3'd3,
        REQ_TRIM       = 3'd4,
        REQ_PEEK_START = 3'd5,
        REQ_PEEK_END   = 3'd6,
        REQ_CLEAR      = 3'd7
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // What the back end does with the ring memory for one command.
    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_WRITE      = 3'd1,
        OP_TAKE       = 3'd2,
        OP_PEEK_START = 3'd3,
        OP_PEEK_END   = 3'd4
    } t_op;

    typedef struct packed {
        t_op                 op;
        t_status             status;
        logic [FILL_W-1:0]   fill;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   pts;
        logic [TIME_W-1:0]   dts;
        logic [TIME_W-1:0]   span;
    } t_cmd;

endpackage

@@ hdl/packet_descriptor_deque.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Bounded double-ended queue of packet descriptors (handle, pts, dts,
// duration) held in a ring of DEPTH entries. Each request transfer gets
// exactly one result transfer, in order, carrying a status (done, empty,
// full), the packet taken if any, the peeked start or end time, and the
// number of entries held afterwards. The front end owns the ring pointers
// and decides every request in the cycle it is accepted; it then hands a
// command through a two-entry queue to the back end, which does the ring
// memory write or read and forms the result. A request is accepted in any
// cycle the command queue has room, so up to three requests can be in the
// block at once. The back end runs one command at a time, the memory access
// (registered read) and then the load of the result register, and pops no
// new command while one is in the memory stage. An accepted request passes
// through the command queue, the memory stage and the result register in
// turn, and its result transfers once the output is not stalled. The ring
// memory needs no clearing after reset; only written entries are ever read.
module packet_descriptor_deque #(
    parameter int DEPTH       = 64,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [pdd_pkg::REQ_W-1:0]           i_req_type,
    input  logic [pdd_pkg::HANDLE_W-1:0]        i_packet_handle,
    input  logic signed [pdd_pkg::TIME_W-1:0]   i_present_time,
    input  logic signed [pdd_pkg::TIME_W-1:0]   i_decode_time,
    input  logic signed [pdd_pkg::TIME_W-1:0]   i_span,
    input  logic [pdd_pkg::LIMIT_W-1:0]         i_keep_limit,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [pdd_pkg::STATUS_W-1:0]        o_status,
    output logic [pdd_pkg::HANDLE_W-1:0]        o_handle_out,
    output logic signed [pdd_pkg::TIME_W-1:0]   o_present_out,
    output logic signed [pdd_pkg::TIME_W-1:0]   o_decode_out,
    output logic signed [pdd_pkg::TIME_W-1:0]   o_span_out,
    output logic signed [pdd_pkg::TIME_W-1:0]   o_peek_time,
    output logic [pdd_pkg::FILL_W-1:0]          o_fill_count
);
    import pdd_pkg::*;

    localparam int AW = $clog2(DEPTH);

    // Front to queue
    logic          w_accept;
    t_cmd          w_front_cmd;
    logic [AW-1:0] w_front_addr;

    // Queue to back
    logic          w_q_full, w_q_valid, w_q_pop;
    t_cmd          w_q_cmd;
    logic [AW-1:0] w_q_addr;

    // Take a request whenever the command queue has room; the front end
    // decides it and updates the ring pointers at this same edge.
    assign w_accept   = i_in_valid && !w_q_full;
    assign o_in_stall = w_q_full;

    pdd_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_req_type      (i_req_type),
        .i_packet_handle (i_packet_handle),
        .i_present_time  (i_present_time),
        .i_decode_time   (i_decode_time),
        .i_span          (i_span),
        .i_keep_limit    (i_keep_limit),
        .o_cmd           (w_front_cmd),
        .o_addr          (w_front_addr)
    );

    // Hold decided commands so the front keeps accepting while the back
    // waits on the memory or on a stalled output.
    pdd_cmd_queue #(
        .AW (AW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_cmd   (w_front_cmd),
        .i_addr  (w_front_addr),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_cmd   (w_q_cmd),
        .o_addr  (w_q_addr)
    );

    // Carry out the memory access and drive the result transfer.
    pdd_back #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .o_q_pop       (w_q_pop),
        .i_cmd         (w_q_cmd),
        .i_addr        (w_q_addr),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_handle_out  (o_handle_out),
        .o_present_out (o_present_out),
        .o_decode_out  (o_decode_out),
        .o_span_out    (o_span_out),
        .o_peek_time   (o_peek_time),
        .o_fill_count  (o_fill_count)
    );

    // A refused append or return only happens with the ring full.
    `ASSERT_ALWAYS(a_full_count, i_clk, i_rst_n, (o_out_valid && o_status == ST_FULL) |-> (o_fill_count == FILL_W'(DEPTH)))
    // An empty status leaves the ring empty and reports no time.
    `ASSERT_ALWAYS(a_empty_result, i_clk, i_rst_n, (o_out_valid && o_status == ST_EMPTY) |-> (o_fill_count == '0 && o_peek_time == NO_TIME))
    // A refused request never hands out a packet.
    `ASSERT_ALWAYS(a_refused_no_handle, i_clk, i_rst_n, (o_out_valid && o_status != ST_DONE) |-> (o_handle_out == '0))
    // The back end pops nothing while a result is stuck at the output.
    `ASSERT_NEXT(a_pop_waits, i_clk, i_rst_n, (o_out_valid && i_out_stall), (!w_q_pop || !i_out_stall || !o_out_valid))

endmodule

@@ hdl/pdd_ram.sv @@
`timescale 1ns / 1ps

module pdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/pdd_front.sv @@
`timescale 1ns / 1ps

module pdd_front #(
    parameter int DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [pdd_pkg::REQ_W-1:0]     i_req_type,
    input  logic [pdd_pkg::HANDLE_W-1:0]  i_packet_handle,
    input  logic [pdd_pkg::TIME_W-1:0]    i_present_time,
    input  logic [pdd_pkg::TIME_W-1:0]    i_decode_time,
    input  logic [pdd_pkg::TIME_W-1:0]    i_span,
    input  logic [pdd_pkg::LIMIT_W-1:0]   i_keep_limit,
    output pdd_pkg::t_cmd                 o_cmd,
    output logic [$clog2(DEPTH)-1:0]      o_addr
);
    import pdd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    logic [AW-1:0] r_oldest, n_oldest;
    logic [CW-1:0] r_count, n_count;
    logic [LW-1:0] w_count_l, w_limit_l, w_drop;
    logic [AW-1:0] w_prev;
    logic          w_full, w_empty;
    t_req          w_req;
    t_op           w_op;
    t_status       w_status;
    logic [AW-1:0] w_addr;

    // Fold a sum below twice the depth back into the ring.
    function automatic logic [AW-1:0] f_wrap(input logic [CW:0] s);
        logic [CW:0] t;
        t = s;
        if (s >= (CW+1)'(DEPTH)) begin
            t = s - (CW+1)'(DEPTH);
        end
        return AW'(t);
    endfunction

    assign w_req     = t_req'(i_req_type);
    assign w_full    = (r_count == CW'(DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_count_l = LW'(r_count);
    assign w_limit_l = LW'(i_keep_limit);
    assign w_drop    = w_count_l - w_limit_l;
    assign w_prev    = (r_oldest == '0) ? AW'(DEPTH - 1) : (r_oldest - AW'(1));

    always_comb begin
        n_oldest = r_oldest;
        n_count  = r_count;
        w_op     = OP_NONE;
        w_status = ST_DONE;
        w_addr   = r_oldest;
        case (w_req)
            REQ_APPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op    = OP_WRITE;
                    w_addr  = f_wrap((CW+1)'(r_oldest) + (CW+1)'(r_count));
                    n_count = r_count + CW'(1);
                end
            end
            REQ_TAKE, REQ_DROP: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_op     = (w_req == REQ_TAKE) ? OP_TAKE : OP_NONE;
                    n_oldest = f_wrap((CW+1)'(r_oldest) + (CW+1)'(1));
                    n_count  = r_count - CW'(1);
                end
            end
            REQ_RETURN: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op     = OP_WRITE;
                    w_addr   = w_prev;
                    n_oldest = w_prev;
                    n_count  = r_count + CW'(1);
                end
            end
            REQ_TRIM: begin
                if (w_count_l > w_limit_l) begin
                    n_oldest = f_wrap((CW+1)'(r_oldest) + (CW+1)'(w_drop));
                    n_count  = CW'(w_limit_l);
                end
            end
            REQ_PEEK_START, REQ_PEEK_END: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_op = (w_req == REQ_PEEK_START) ? OP_PEEK_START : OP_PEEK_END;
                end
            end
            REQ_CLEAR: begin
                n_oldest = '0;
                n_count  = '0;
            end
            default: begin
                n_oldest = r_oldest;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_count  <= '0;
        end else if (i_accept) begin
            r_oldest <= n_oldest;
            r_count  <= n_count;
        end
    end

    assign o_cmd.op     = w_op;
    assign o_cmd.status = w_status;
    assign o_cmd.fill   = FILL_W'(n_count);
    assign o_cmd.handle = i_packet_handle;
    assign o_cmd.pts    = i_present_time;
    assign o_cmd.dts    = i_decode_time;
    assign o_cmd.span   = i_span;
    assign o_addr       = w_addr;

endmodule

@@ hdl/pdd_cmd_queue.sv @@
`timescale 1ns / 1ps

module pdd_cmd_queue #(
    parameter int AW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pdd_pkg::t_cmd i_cmd,
    input  logic [AW-1:0] i_addr,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output pdd_pkg::t_cmd o_cmd,
    output logic [AW-1:0] o_addr
);
    import pdd_pkg::*;

    t_cmd          r_cmd  [2];
    logic [AW-1:0] r_addr [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cmd[r_wp]  <= i_cmd;
            r_addr[r_wp] <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_cmd[r_rp];
    assign o_addr  = r_addr[r_rp];

endmodule

@@ hdl/pdd_back.sv @@
`timescale 1ns / 1ps

module pdd_back #(
    parameter int DEPTH       = 64,
    parameter int HANDLE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    output logic                         o_q_pop,
    input  pdd_pkg::t_cmd                i_cmd,
    input  logic [$clog2(DEPTH)-1:0]     i_addr,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [pdd_pkg::STATUS_W-1:0] o_status,
    output logic [pdd_pkg::HANDLE_W-1:0] o_handle_out,
    output logic [pdd_pkg::TIME_W-1:0]   o_present_out,
    output logic [pdd_pkg::TIME_W-1:0]   o_decode_out,
    output logic [pdd_pkg::TIME_W-1:0]   o_span_out,
    output logic [pdd_pkg::TIME_W-1:0]   o_peek_time,
    output logic [pdd_pkg::FILL_W-1:0]   o_fill_count
);
    import pdd_pkg::*;

    localparam int DW = HANDLE_BITS + 3 * TIME_W;

    logic                w_pop, w_we, w_re;
    logic [DW-1:0]       w_wdata, w_rdata;
    logic [TIME_W-1:0]   w_rd_pts, w_rd_dts, w_rd_span, w_start, w_end;
    logic [TIME_W:0]     w_sum;
    logic                w_span_pos, w_ovf;

    logic                r_pend;
    t_op                 r_pend_op;
    t_status             r_pend_status;
    logic [FILL_W-1:0]   r_pend_fill;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic [TIME_W-1:0]   r_pts, n_pts, r_dts, n_dts, r_span, n_span, r_peek, n_peek;
    logic [FILL_W-1:0]   r_fill;

    // One command in flight: pop only when the memory stage is free and the
    // output register is empty or being taken.
    assign w_pop = i_q_valid && !r_pend && (!r_out_valid || !i_out_stall);
    assign w_we  = w_pop && (i_cmd.op == OP_WRITE);
    assign w_re  = w_pop && (i_cmd.op == OP_TAKE || i_cmd.op == OP_PEEK_START ||
                             i_cmd.op == OP_PEEK_END);

    assign w_wdata = {HANDLE_BITS'(i_cmd.handle), i_cmd.pts, i_cmd.dts, i_cmd.span};

    pdd_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (i_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    assign w_rd_pts  = w_rdata[3*TIME_W-1 -: TIME_W];
    assign w_rd_dts  = w_rdata[2*TIME_W-1 -: TIME_W];
    assign w_rd_span = w_rdata[TIME_W-1:0];

    // Start falls back from pts to dts; end is no time when start is, and
    // otherwise adds a positive span unless the sum overflows.
    assign w_start    = (w_rd_pts != NO_TIME) ? w_rd_pts : w_rd_dts;
    assign w_sum      = {w_start[TIME_W-1], w_start} + {w_rd_span[TIME_W-1], w_rd_span};
    assign w_span_pos = !w_rd_span[TIME_W-1] && (w_rd_span != '0);
    assign w_ovf      = (w_sum[TIME_W] != w_sum[TIME_W-1]);
    assign w_end      = (w_start == NO_TIME) ? NO_TIME :
                        (w_span_pos && !w_ovf) ? w_sum[TIME_W-1:0] : w_start;

    always_comb begin
        n_status = STATUS_W'(r_pend_status);
        n_handle = '0;
        n_pts    = '0;
        n_dts    = '0;
        n_span   = '0;
        n_peek   = NO_TIME;
        case (r_pend_op)
            OP_TAKE: begin
                n_handle = HANDLE_W'(w_rdata[DW-1 -: HANDLE_BITS]);
                n_pts    = w_rd_pts;
                n_dts    = w_rd_dts;
                n_span   = w_rd_span;
            end
            OP_PEEK_START: begin
                n_peek = w_start;
            end
            OP_PEEK_END: begin
                n_peek = w_end;
            end
            default: begin
                n_peek = NO_TIME;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= w_pop;
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_pend_op     <= i_cmd.op;
            r_pend_status <= i_cmd.status;
            r_pend_fill   <= i_cmd.fill;
        end
        if (r_pend) begin
            r_status <= n_status;
            r_handle <= n_handle;
            r_pts    <= n_pts;
            r_dts    <= n_dts;
            r_span   <= n_span;
            r_peek   <= n_peek;
            r_fill   <= r_pend_fill;
        end
    end

    assign o_q_pop       = w_pop;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_handle_out  = r_handle;
    assign o_present_out = r_pts;
    assign o_decode_out  = r_dts;
    assign o_span_out    = r_span;
    assign o_peek_time   = r_peek;
    assign o_fill_count  = r_fill;

endmodule
